// ===== design/three_sum_zero_triples_macros.svh =====
// ---------------------------------------------------------------------------
// three_sum_zero_triples_macros.svh
// assertion macros shared by the zero-sum triple finder
// ---------------------------------------------------------------------------
`ifndef THREE_SUM_ZERO_TRIPLES_MACROS_SVH
`define THREE_SUM_ZERO_TRIPLES_MACROS_SVH

// same-cycle implication
`define TSZ_ASSERT_SAME(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TSZ_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/tsz_pkg.sv =====
// ---------------------------------------------------------------------------
// tsz_pkg
// state codes and fixed widths of the zero-sum triple finder
// ---------------------------------------------------------------------------
package tsz_pkg;

	localparam int FIELD_BITS = 16;
	localparam int STATE_BITS = 4;

	typedef logic [STATE_BITS-1:0] state_t;

	localparam state_t ST_IDLE  = 4'd0;
	localparam state_t ST_INS   = 4'd1;
	localparam state_t ST_INS0  = 4'd2;
	localparam state_t ST_SR_I  = 4'd3;
	localparam state_t ST_W_I   = 4'd4;
	localparam state_t ST_W_J   = 4'd5;
	localparam state_t ST_W_B   = 4'd6;
	localparam state_t ST_W_C   = 4'd7;
	localparam state_t ST_CMP   = 4'd8;
	localparam state_t ST_SKJ   = 4'd9;
	localparam state_t ST_SKJ_W = 4'd10;
	localparam state_t ST_SKK   = 4'd11;
	localparam state_t ST_SKK_W = 4'd12;
	localparam state_t ST_EMIT  = 4'd13;

endpackage

// ===== design/tsz_ram.sv =====
// ---------------------------------------------------------------------------
// tsz_ram
// single write port, single registered read port memory
// ---------------------------------------------------------------------------
module tsz_ram #(
	parameter int DEPTH     = 16,
	parameter int ADDR_BITS = 4,
	parameter int WIDTH     = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/three_sum_zero_triples.sv =====
// ---------------------------------------------------------------------------
// three_sum_zero_triples
// loads a set of signed values in sorted order, then lists every distinct
// zero-sum triple with the sorted two-pointer method
// ---------------------------------------------------------------------------
// An input transaction is taken when start is high and busy is low. Each value
// is inserted into a sorted element memory: the first value of a set is written
// at once without raising busy, any later one shifts each stored element larger
// than the new value up one slot and then takes the freed slot. The transaction
// flagged last_value starts the search, which walks the element memory through
// its single read port. Triples found go to a triple buffer; once the search
// ends the buffer is streamed out at one result per cycle, each marked by a
// one-cycle strobe. The receiver cannot stall, so results must be taken as
// they come. truncated is known only when the search ends, which is why the
// whole answer is held back until then. busy is high while a value is being
// inserted, and from the start of a search until the last result has been
// issued. With no triple a single result with triple_valid low is sent. Values
// beyond MAX_ELEMENTS are dropped and flag truncated; so does a triple beyond
// MAX_TRIPLES.
// ---------------------------------------------------------------------------
module three_sum_zero_triples
	import tsz_pkg::*;
#(
	parameter int MAX_ELEMENTS = 16,
	parameter int VALUE_BITS   = 16,
	parameter int MAX_TRIPLES  = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [FIELD_BITS-1:0] value,
	input  logic                         last_value,
	output logic                         strobe,
	output logic signed [FIELD_BITS-1:0] first,
	output logic signed [FIELD_BITS-1:0] second,
	output logic signed [FIELD_BITS-1:0] third,
	output logic                         triple_valid,
	output logic                         truncated,
	output logic                         last_result
);

`include "three_sum_zero_triples_macros.svh"

	localparam int CW  = $clog2(MAX_ELEMENTS + 1);
	localparam int IW  = $clog2(MAX_ELEMENTS);
	localparam int TW  = $clog2(MAX_TRIPLES + 1);
	localparam int BAW = (MAX_TRIPLES > 1) ? $clog2(MAX_TRIPLES) : 1;
	localparam int VB  = VALUE_BITS;
	localparam int SW  = VALUE_BITS + 2;

	typedef logic signed [VB-1:0] val_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic            ovf_q;
	logic            last_q;
	val_t            v_q;
	logic [IW-1:0]   pos_q;
	logic [IW-1:0]   i_q, j_q, k_q;
	val_t            a_q, b_q, c_q, prev_q, ob_q, oc_q;
	logic            pv_q;
	logic [TW-1:0]   found_q;
	logic [TW-1:0]   r_q;
	logic            more_q;

	// result pipeline, aligned with the triple buffer read data
	logic            strobe_s1, tv_s1, last_s1, trunc_s1;

	// element memory ports
	logic            st_we;
	logic [IW-1:0]   st_waddr, st_raddr;
	logic [VB-1:0]   st_wdata, st_rdata;
	val_t            rd;

	// triple buffer ports
	logic            tb_we;
	logic [3*VB-1:0] tb_rdata;

	logic            accept;
	logic signed [SW-1:0] sum;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign rd     = val_t'(st_rdata);
	assign sum    = SW'(a_q) + SW'(b_q) + SW'(c_q);

	tsz_ram #(.DEPTH(MAX_ELEMENTS), .ADDR_BITS(IW), .WIDTH(VB)) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	tsz_ram #(.DEPTH(MAX_TRIPLES), .ADDR_BITS(BAW), .WIDTH(3*VB)) u_tbuf (
		.clk   (clk),
		.we    (tb_we),
		.waddr (found_q[BAW-1:0]),
		.wdata ({a_q, b_q, c_q}),
		.raddr (r_q[BAW-1:0]),
		.rdata (tb_rdata)
	);

	// element memory write: shift during insert, or place the new value
	always_comb begin
		st_we    = 1'b0;
		st_waddr = pos_q;
		st_wdata = v_q;
		if (accept && count_q == '0) begin
			st_we    = 1'b1;
			st_waddr = '0;
			st_wdata = VB'($unsigned(value));
		end else if (state_q == ST_INS) begin
			st_we    = 1'b1;
			st_wdata = (rd > v_q) ? st_rdata : v_q;
		end else if (state_q == ST_INS0) begin
			st_we    = 1'b1;
			st_waddr = '0;
		end
	end

	// element memory read address, issued in the cycle before its data is used
	always_comb begin
		st_raddr = i_q;
		unique case (state_q)
			ST_IDLE:  st_raddr = IW'(count_q - CW'(1));
			ST_INS:   st_raddr = pos_q - IW'(2);
			ST_SR_I:  st_raddr = i_q;
			ST_W_I:   st_raddr = i_q + IW'(1);
			ST_W_J:   st_raddr = k_q;
			ST_CMP:   st_raddr = (sum < 0) ? j_q + IW'(1) : k_q - IW'(1);
			ST_SKJ:   st_raddr = j_q;
			ST_SKK:   st_raddr = k_q;
			default:  st_raddr = i_q;
		endcase
	end

	assign tb_we = (state_q == ST_CMP) && (j_q < k_q) && (sum == '0)
		&& (found_q != TW'(MAX_TRIPLES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			found_q   <= '0;
			r_q       <= '0;
			more_q    <= 1'b0;
			pv_q      <= 1'b0;
			strobe_s1 <= 1'b0;
			tv_s1     <= 1'b0;
			last_s1   <= 1'b0;
			trunc_s1  <= 1'b0;
		end else begin
			strobe_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						v_q    <= VB'($unsigned(value));
						last_q <= last_value;
						pos_q  <= count_q[IW-1:0];
						i_q    <= '0;
						pv_q   <= 1'b0;
						found_q <= '0;
						more_q <= 1'b0;
						if (count_q == CW'(MAX_ELEMENTS)) begin
							ovf_q <= 1'b1;
							if (last_value) begin
								state_q <= ST_SR_I;
							end
						end else if (count_q == '0) begin
							count_q <= count_q + CW'(1);
							if (last_value) begin
								state_q <= ST_SR_I;
							end
						end else begin
							state_q <= ST_INS;
						end
					end
				end
				ST_INS: begin
					// shift a larger neighbor up, or drop the value in its slot
					if (rd > v_q) begin
						pos_q <= pos_q - IW'(1);
						if (pos_q == IW'(1)) begin
							state_q <= ST_INS0;
						end
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= last_q ? ST_SR_I : ST_IDLE;
					end
				end
				ST_INS0: begin
					count_q <= count_q + CW'(1);
					state_q <= last_q ? ST_SR_I : ST_IDLE;
				end
				ST_SR_I: begin
					if ((CW+1)'(i_q) + (CW+1)'(2) < (CW+1)'(count_q)) begin
						state_q <= ST_W_I;
					end else begin
						r_q     <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_W_I: begin
					// skip a repeated first value
					if (pv_q && rd == prev_q) begin
						i_q     <= i_q + IW'(1);
						state_q <= ST_SR_I;
					end else begin
						a_q     <= rd;
						prev_q  <= rd;
						pv_q    <= 1'b1;
						j_q     <= i_q + IW'(1);
						k_q     <= IW'(count_q - CW'(1));
						state_q <= ST_W_J;
					end
				end
				ST_W_J: begin
					b_q     <= rd;
					state_q <= ST_W_C;
				end
				ST_W_B: begin
					b_q     <= rd;
					state_q <= ST_CMP;
				end
				ST_W_C: begin
					c_q     <= rd;
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (j_q >= k_q) begin
						i_q     <= i_q + IW'(1);
						state_q <= ST_SR_I;
					end else if (sum == '0) begin
						if (found_q == TW'(MAX_TRIPLES)) begin
							more_q  <= 1'b1;
							r_q     <= '0;
							state_q <= ST_EMIT;
						end else begin
							found_q <= found_q + TW'(1);
							ob_q    <= b_q;
							oc_q    <= c_q;
							j_q     <= j_q + IW'(1);
							k_q     <= k_q - IW'(1);
							state_q <= ST_SKJ;
						end
					end else if (sum < 0) begin
						j_q     <= j_q + IW'(1);
						state_q <= ST_W_B;
					end else begin
						k_q     <= k_q - IW'(1);
						state_q <= ST_W_C;
					end
				end
				ST_SKJ: begin
					state_q <= (j_q < k_q) ? ST_SKJ_W : ST_CMP;
				end
				ST_SKJ_W: begin
					if (rd == ob_q) begin
						j_q     <= j_q + IW'(1);
						state_q <= ST_SKJ;
					end else begin
						b_q     <= rd;
						state_q <= ST_SKK;
					end
				end
				ST_SKK: begin
					state_q <= (k_q > j_q) ? ST_SKK_W : ST_CMP;
				end
				ST_SKK_W: begin
					if (rd == oc_q) begin
						k_q     <= k_q - IW'(1);
						state_q <= ST_SKK;
					end else begin
						c_q     <= rd;
						state_q <= ST_CMP;
					end
				end
				ST_EMIT: begin
					// one result per cycle, buffer data lands next cycle
					strobe_s1 <= 1'b1;
					trunc_s1  <= ovf_q | more_q;
					tv_s1     <= (found_q != '0);
					r_q       <= r_q + TW'(1);
					if (found_q == '0 || r_q == found_q - TW'(1)) begin
						last_s1 <= 1'b1;
						count_q <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						last_s1 <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output fields, sign-extended or cut to the port width
	logic signed [FIELD_BITS-1:0] f_a, f_b, f_c;
	assign f_a = FIELD_BITS'(val_t'(tb_rdata[3*VB-1:2*VB]));
	assign f_b = FIELD_BITS'(val_t'(tb_rdata[2*VB-1:VB]));
	assign f_c = FIELD_BITS'(val_t'(tb_rdata[VB-1:0]));

	assign strobe       = strobe_s1;
	assign triple_valid = tv_s1;
	assign truncated    = trunc_s1;
	assign last_result  = last_s1;
	assign first        = tv_s1 ? f_a : '0;
	assign second       = tv_s1 ? f_b : '0;
	assign third        = tv_s1 ? f_c : '0;

	`TSZ_ASSERT_SAME(a_count_cap, clk, arst_n, 1'b1, count_q <= CW'(MAX_ELEMENTS), "element count past capacity")
	`TSZ_ASSERT_SAME(a_found_cap, clk, arst_n, 1'b1, found_q <= TW'(MAX_TRIPLES), "triple count past limit")
	`TSZ_ASSERT_NEXT(a_emit_strobe, clk, arst_n, state_q == ST_EMIT, strobe_s1, "emit cycle without strobe")
	`TSZ_ASSERT_NEXT(a_last_gap, clk, arst_n, strobe_s1 && last_s1, !strobe_s1, "result after last result")
	`TSZ_ASSERT_SAME(a_ptr_order, clk, arst_n, state_q == ST_CMP && tb_we, i_q < j_q, "pointer order broken on match")

endmodule
